// ===== rtl/ugrq_pkg.sv =====
// ---------------------------------------------------------------------------
// ugrq_pkg
// Shared types and codes of the uniform-grid radius query block.
// ---------------------------------------------------------------------------
package ugrq_pkg;

  // field widths of the stream items
  localparam int unsigned ActionW = 2;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned TotalW  = 16;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned HitsW   = 7;
  localparam int unsigned HitCap  = 64;

  // action codes
  localparam logic [ActionW-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ActionW-1:0] ACT_INSERT = 2'd1;
  localparam logic [ActionW-1:0] ACT_QUERY  = 2'd2;

  // reply kinds
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 2'd1;
  localparam logic [KindW-1:0] KIND_HIT    = 2'd2;
  localparam logic [KindW-1:0] KIND_EMPTY  = 2'd3;

  // configuration register indexes
  localparam logic REG_CELL_SHIFT = 1'b0;
  localparam logic REG_MAX_HITS   = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_CLR_DONE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_Q_SETUP,
    ST_Q_CELL,
    ST_Q_FILL,
    ST_Q_SLOT,
    ST_Q_MEMW,
    ST_Q_POSW,
    ST_Q_MUL,
    ST_Q_CMP,
    ST_Q_HIT,
    ST_Q_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic sweep_start;
    logic sweep_wr;
    logic clr_total;
    logic ins_commit;
    logic q_setup;
    logic q_fill_ld;
    logic q_next_cell;
    logic q_slot_inc;
    logic q_abs;
    logic q_mul;
    logic q_hit;
    logic emit_clear;
    logic emit_insert;
    logic emit_pend;
    logic emit_final;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_end;
    logic limit_hit;
    logic slot_more;
    logic last_cell;
    logic member_bad;
    logic is_hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ugrq_ram.sv =====
// ---------------------------------------------------------------------------
// ugrq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ugrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ugrq_ctrl.sv =====
// ---------------------------------------------------------------------------
// ugrq_ctrl
// Sequencer for clear sweep, insert and cell-by-cell query walk.
// ---------------------------------------------------------------------------
module ugrq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [ugrq_pkg::ActionW-1:0] action,
  input  ugrq_pkg::sts_t          sts,
  output ugrq_pkg::cmd_t          cmd
);
  import ugrq_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.sweep_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          case (action)
            ACT_CLEAR:  state_next = ST_CLR;
            ACT_INSERT: state_next = ST_INS_RD;
            ACT_QUERY:  state_next = ST_Q_SETUP;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        if (sts.sweep_end) state_next = ST_CLR_DONE;
      end
      ST_CLR_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_INS_RD:  state_next = ST_INS_CHK;
      ST_INS_CHK: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_Q_SETUP: state_next = ST_Q_CELL;
      ST_Q_CELL: begin
        if (sts.limit_hit) state_next = ST_Q_DONE;
        else state_next = ST_Q_FILL;
      end
      ST_Q_FILL: state_next = ST_Q_SLOT;
      ST_Q_SLOT: begin
        if (sts.limit_hit) state_next = ST_Q_DONE;
        else if (sts.slot_more) state_next = ST_Q_MEMW;
        else if (sts.last_cell) state_next = ST_Q_DONE;
        else state_next = ST_Q_CELL;
      end
      ST_Q_MEMW: begin
        if (sts.member_bad) state_next = ST_Q_SLOT;
        else state_next = ST_Q_POSW;
      end
      ST_Q_POSW: state_next = ST_Q_MUL;
      ST_Q_MUL:  state_next = ST_Q_CMP;
      ST_Q_CMP: begin
        if (sts.is_hit) state_next = ST_Q_HIT;
        else state_next = ST_Q_SLOT;
      end
      ST_Q_HIT: begin
        if (!sts.pend_valid || sts.out_free) state_next = ST_Q_SLOT;
      end
      ST_Q_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
      end
      ST_IDLE: begin
        cmd.latch       = take;
        cmd.sweep_start = take && (action == ACT_CLEAR);
      end
      ST_CLR: begin
        cmd.sweep_wr  = 1'b1;
        cmd.clr_total = sts.sweep_end;
      end
      ST_CLR_DONE: begin
        cmd.emit_clear = sts.out_free;
      end
      ST_INS_CHK: begin
        cmd.ins_commit  = sts.out_free;
        cmd.emit_insert = sts.out_free;
      end
      ST_Q_SETUP: begin
        cmd.q_setup = 1'b1;
      end
      ST_Q_FILL: begin
        cmd.q_fill_ld = 1'b1;
      end
      ST_Q_SLOT: begin
        cmd.q_next_cell = !sts.limit_hit && !sts.slot_more && !sts.last_cell;
      end
      ST_Q_MEMW: begin
        cmd.q_slot_inc = sts.member_bad;
      end
      ST_Q_POSW: begin
        cmd.q_abs = 1'b1;
      end
      ST_Q_MUL: begin
        cmd.q_mul = 1'b1;
      end
      ST_Q_CMP: begin
        cmd.q_slot_inc = !sts.is_hit;
      end
      ST_Q_HIT: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.q_hit      = 1'b1;
          cmd.q_slot_inc = 1'b1;
          cmd.emit_pend  = sts.pend_valid;
        end
      end
      ST_Q_DONE: begin
        cmd.emit_final = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/ugrq_dp.sv =====
// ---------------------------------------------------------------------------
// ugrq_dp
// Datapath: grid stores, cell mapping, distance test and output register.
// ---------------------------------------------------------------------------
module ugrq_dp #(
  parameter int unsigned GRID_COLUMNS   = 32,
  parameter int unsigned GRID_ROWS_N    = 32,
  parameter int unsigned SLOTS_PER_CELL = 32,
  parameter int unsigned MAX_POINTS     = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ugrq_pkg::cmd_t                 cmd,
  output ugrq_pkg::sts_t                 sts,
  input  logic [ugrq_pkg::ShiftW-1:0]    cell_shift,
  input  logic [ugrq_pkg::HitsW-1:0]     max_hits,
  input  logic [ugrq_pkg::IndexW-1:0]    in_index,
  input  logic [ugrq_pkg::CoordW-1:0]    in_x,
  input  logic [ugrq_pkg::CoordW-1:0]    in_y,
  input  logic [ugrq_pkg::RadiusW-1:0]   in_radius,
  input  logic [ugrq_pkg::ActionW-1:0]   in_action,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ugrq_pkg::KindW-1:0]     out_kind,
  output logic [ugrq_pkg::IndexW-1:0]    out_index,
  output logic                           out_accepted,
  output logic [ugrq_pkg::TotalW-1:0]    out_total,
  output logic                           out_last
);
  import ugrq_pkg::*;

  localparam int unsigned CELLS   = GRID_COLUMNS * GRID_ROWS_N;
  localparam int unsigned CW      = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int unsigned RW      = (GRID_ROWS_N > 1) ? $clog2(GRID_ROWS_N) : 1;
  localparam int unsigned CAW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned MDEPTH  = CELLS * SLOTS_PER_CELL;
  localparam int unsigned MAW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int unsigned FW      = $clog2(SLOTS_PER_CELL + 1);
  localparam int unsigned PDEPTH  = (MAX_POINTS < 4096) ? MAX_POINTS : 4096;
  localparam int unsigned PAW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int unsigned ReachW  = RadiusW + 1;
  localparam int unsigned SumW    = ReachW + 1;

  // latched item
  logic [IndexW-1:0]  idx;
  logic [CoordW-1:0]  px;
  logic [CoordW-1:0]  py;
  logic [RadiusW-1:0] radius;
  logic [ActionW-1:0] act;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx    <= in_index;
      px     <= in_x;
      py     <= in_y;
      radius <= in_radius;
      act    <= in_action;
    end
  end

  // clamp a coordinate into a grid column or row
  function automatic logic [CoordW-1:0] cell_coord(logic [CoordW-1:0] p,
                                                   logic [ShiftW-1:0] sh,
                                                   logic [CoordW-1:0] lim);
    logic [CoordW-1:0] u;
    u = p >> sh;
    if (p[CoordW-1]) return '0;
    if (u > lim) return lim;
    return u;
  endfunction

  logic [CoordW-1:0] c0_w;
  logic [CoordW-1:0] r0_w;
  logic [CW-1:0]     c0;
  logic [RW-1:0]     r0;

  assign c0_w = cell_coord(px, cell_shift, CoordW'(GRID_COLUMNS - 1));
  assign r0_w = cell_coord(py, cell_shift, CoordW'(GRID_ROWS_N - 1));
  assign c0   = c0_w[CW-1:0];
  assign r0   = r0_w[RW-1:0];

  // query window bounds
  logic [ReachW-1:0] reach;
  logic [SumW-1:0]   csum;
  logic [SumW-1:0]   rsum;
  logic [CW-1:0]     minc_w;
  logic [CW-1:0]     maxc_w;
  logic [RW-1:0]     minr_w;
  logic [RW-1:0]     maxr_w;

  assign reach  = ReachW'(radius >> cell_shift) + ReachW'(1);
  assign csum   = SumW'(c0) + SumW'(reach);
  assign rsum   = SumW'(r0) + SumW'(reach);
  assign minc_w = (ReachW'(c0) <= reach) ? '0 : CW'(ReachW'(c0) - reach);
  assign minr_w = (ReachW'(r0) <= reach) ? '0 : RW'(ReachW'(r0) - reach);
  assign maxc_w = (csum > SumW'(GRID_COLUMNS - 1)) ? CW'(GRID_COLUMNS - 1) : csum[CW-1:0];
  assign maxr_w = (rsum > SumW'(GRID_ROWS_N - 1)) ? RW'(GRID_ROWS_N - 1) : rsum[RW-1:0];

  logic [CW-1:0]       minc;
  logic [CW-1:0]       maxc;
  logic [RW-1:0]       maxr;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [2*RadiusW-1:0] rsq;
  logic [FW-1:0]       fill;
  logic [FW-1:0]       slot;
  logic [HitsW-1:0]    found;
  logic [HitsW-1:0]    limit;

  assign limit = (max_hits > HitsW'(HitCap)) ? HitsW'(HitCap) : max_hits;

  // walk position over the window
  always_ff @(posedge clk) begin
    if (cmd.q_setup) begin
      minc <= minc_w;
      maxc <= maxc_w;
      maxr <= maxr_w;
      col  <= minc_w;
      row  <= minr_w;
      rsq  <= radius * radius;
    end else if (cmd.q_next_cell) begin
      if (col == maxc) begin
        col <= minc;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // cell addresses
  logic [CAW-1:0] q_cell;
  logic [CAW-1:0] ins_cell;
  logic [CAW-1:0] sweep_cnt;

  assign q_cell   = CAW'(row * GRID_COLUMNS) + CAW'(col);
  assign ins_cell = CAW'(r0 * GRID_COLUMNS) + CAW'(c0);

  // fill count store
  logic           fill_we;
  logic [CAW-1:0] fill_waddr;
  logic [FW-1:0]  fill_wdata;
  logic [FW-1:0]  fill_rdata;
  logic           ins_ok;

  assign ins_ok     = (32'(idx) < MAX_POINTS) && (fill_rdata < FW'(SLOTS_PER_CELL));
  assign fill_we    = cmd.sweep_wr || (cmd.ins_commit && ins_ok);
  assign fill_waddr = cmd.sweep_wr ? sweep_cnt : ins_cell;
  assign fill_wdata = cmd.sweep_wr ? '0 : fill_rdata + FW'(1);

  ugrq_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr ((act == ACT_QUERY) ? q_cell : ins_cell),
    .rdata (fill_rdata)
  );

  // cell member store
  logic [IndexW-1:0] mem_rdata;

  ugrq_ram #(.WIDTH(IndexW), .DEPTH(MDEPTH)) u_members (
    .clk   (clk),
    .we    (cmd.ins_commit && ins_ok),
    .waddr (MAW'(ins_cell * SLOTS_PER_CELL) + MAW'(fill_rdata)),
    .wdata (idx),
    .raddr (MAW'(q_cell * SLOTS_PER_CELL) + MAW'(slot)),
    .rdata (mem_rdata)
  );

  // point position store, {y, x}
  logic [2*CoordW-1:0] pos_rdata;

  ugrq_ram #(.WIDTH(2*CoordW), .DEPTH(PDEPTH)) u_pos (
    .clk   (clk),
    .we    (cmd.ins_commit && ins_ok),
    .waddr (PAW'(idx)),
    .wdata ({py, px}),
    .raddr (PAW'(mem_rdata)),
    .rdata (pos_rdata)
  );

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_cnt <= sweep_cnt + CAW'(1);
    end
  end

  // slot walk; the hit count is kept with the pending hit below
  always_ff @(posedge clk) begin
    if (cmd.q_fill_ld) begin
      fill <= fill_rdata;
      slot <= '0;
    end else if (cmd.q_slot_inc) begin
      slot <= slot + FW'(1);
    end
  end

  // distance test: difference, square, compare
  logic signed [CoordW:0] dx;
  logic signed [CoordW:0] dy;
  logic [CoordW:0]        adx;
  logic [CoordW:0]        ady;
  logic [CoordW-1:0]      ax;
  logic [CoordW-1:0]      ay;
  logic [2*CoordW-1:0]    sqx;
  logic [2*CoordW-1:0]    sqy;
  logic [2*CoordW:0]      dsum;

  assign dx  = $signed({pos_rdata[CoordW-1], pos_rdata[CoordW-1:0]}) -
               $signed({px[CoordW-1], px});
  assign dy  = $signed({pos_rdata[2*CoordW-1], pos_rdata[2*CoordW-1:CoordW]}) -
               $signed({py[CoordW-1], py});
  assign adx = dx[CoordW] ? (CoordW+1)'(-dx) : dx;
  assign ady = dy[CoordW] ? (CoordW+1)'(-dy) : dy;

  always_ff @(posedge clk) begin
    if (cmd.q_abs) begin
      ax <= adx[CoordW-1:0];
      ay <= ady[CoordW-1:0];
    end
    if (cmd.q_mul) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
  end

  assign dsum = (2*CoordW+1)'(sqx) + (2*CoordW+1)'(sqy);

  // pending hit holds back one reply so the final one carries last
  logic              pend_valid;
  logic [IndexW-1:0] pend_index;

  always_ff @(posedge clk) begin
    if (cmd.q_setup) begin
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (cmd.q_hit) begin
      pend_valid <= 1'b1;
      pend_index <= mem_rdata;
      found      <= found + HitsW'(1);
    end
  end

  // successful insert count
  logic [TotalW-1:0] total;
  logic [TotalW-1:0] total_inc;

  assign total_inc = (total == '1) ? total : total + TotalW'(1);

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_total) begin
      total <= '0;
    end else if (cmd.ins_commit && ins_ok) begin
      total <= total_inc;
    end
  end

  // output register
  logic emit;
  assign emit = cmd.emit_clear || cmd.emit_insert || cmd.emit_pend || cmd.emit_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index    <= '0;
      out_accepted <= 1'b0;
      out_total    <= total;
      out_last     <= 1'b1;
      if (cmd.emit_clear) begin
        out_kind <= KIND_CLEAR;
      end else if (cmd.emit_insert) begin
        out_kind     <= KIND_INSERT;
        out_accepted <= ins_ok;
        out_total    <= ins_ok ? total_inc : total;
      end else if (cmd.emit_pend) begin
        out_kind  <= KIND_HIT;
        out_index <= pend_index;
        out_last  <= 1'b0;
      end else if (pend_valid) begin
        out_kind  <= KIND_HIT;
        out_index <= pend_index;
      end else begin
        out_kind <= KIND_EMPTY;
      end
    end
  end

  // status
  assign sts.sweep_end  = (sweep_cnt == CAW'(CELLS - 1));
  assign sts.limit_hit  = (found >= limit);
  assign sts.slot_more  = (slot < fill);
  assign sts.last_cell  = (col == maxc) && (row == maxr);
  assign sts.member_bad = (32'(mem_rdata) >= MAX_POINTS);
  assign sts.is_hit     = (dsum <= (2*CoordW+1)'(rsq));
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/uniform_grid_radius_query.sv =====
// ---------------------------------------------------------------------------
// uniform_grid_radius_query
// Uniform-grid point index with clear, insert and radius query.
//
//   channel  direction  transfer carries
//   s_*      in         action (tuser), index, x, y, radius (tdata)
//   m_*      out        reply kind (tuser), hit index, accepted, total, last
//   apb      in/out     cell_shift at 0x0, max_hits at 0x4
//
// After reset the fill counts are swept to zero, one cell a cycle, before the
// first item is taken; a clear action repeats that sweep. An insert reads its
// cell's fill count, then, if accepted, writes member, position and new count.
// A query sets up its window, reads the fill count of each cell in it and, for
// each entry, reads member index and position, squares the distances and
// compares, with a further step per hit. One item is worked at a time; a held
// output stalls the walk only when a new reply must be sent.
// ---------------------------------------------------------------------------
module uniform_grid_radius_query #(
  parameter int unsigned GRID_COLUMNS   = 32,
  parameter int unsigned GRID_ROWS_N    = 32,
  parameter int unsigned SLOTS_PER_CELL = 32,
  parameter int unsigned MAX_POINTS     = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // item_index[11:0], point_x[27:12], point_y[43:28], radius[59:44]
  input  logic [63:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // found_index[11:0], accepted[12], inserted_total[28:13]
  output logic [31:0] m_tdata,
  // reply_kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ugrq_pkg::*;

  // configuration registers
  logic [ShiftW-1:0] cell_shift;
  logic [HitsW-1:0]  max_hits;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_shift <= ShiftW'(5);
      max_hits   <= HitsW'(64);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CELL_SHIFT: cell_shift <= pwdata[ShiftW-1:0];
        REG_MAX_HITS:   max_hits   <= pwdata[HitsW-1:0];
        default:        cell_shift <= cell_shift;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_CELL_SHIFT: prdata = 32'(cell_shift);
      REG_MAX_HITS:   prdata = 32'(max_hits);
      default:        prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  ugrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  logic [IndexW-1:0] out_index;
  logic              out_accepted;
  logic [TotalW-1:0] out_total;

  ugrq_dp #(
    .GRID_COLUMNS   (GRID_COLUMNS),
    .GRID_ROWS_N    (GRID_ROWS_N),
    .SLOTS_PER_CELL (SLOTS_PER_CELL),
    .MAX_POINTS     (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cell_shift   (cell_shift),
    .max_hits     (max_hits),
    .in_index     (s_tdata[11:0]),
    .in_x         (s_tdata[27:12]),
    .in_y         (s_tdata[43:28]),
    .in_radius    (s_tdata[59:44]),
    .in_action    (s_tuser),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_kind     (m_tuser),
    .out_index    (out_index),
    .out_accepted (out_accepted),
    .out_total    (out_total),
    .out_last     (m_tlast)
  );

  assign m_tdata = {3'b000, out_total, out_accepted, out_index};

endmodule
